FILE: rtl/tcdq_pkg.sv
// Shared types and constants of the tone curve dither quantizer.
package tcdq_pkg;

  localparam int KNOTS = 16;
  localparam int TONE_W = 8;
  localparam int LEVEL_W = 4;
  localparam int CFG_W = 64;

  localparam logic [TONE_W-1:0] BLACK_TONE = 8'd0;
  localparam logic [TONE_W-1:0] WHITE_TONE = 8'd255;
  localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 4'd15;
  localparam logic [LEVEL_W-1:0] BLACK_LEVEL = 4'd0;

  // register indexes
  localparam logic CFG_KNOTS_LOW = 1'b0;
  localparam logic CFG_KNOTS_HIGH = 1'b1;

  localparam logic [CFG_W-1:0] KNOTS_LOW_RESET = 64'h7766554433221100;
  localparam logic [CFG_W-1:0] KNOTS_HIGH_RESET = 64'hFFEEDDCCBBAA9988;

  typedef logic [KNOTS-1:0][TONE_W-1:0] knot_array_t;

  // after the knot compares
  typedef struct packed {
    logic [TONE_W-1:0] sample;
    logic [TONE_W-1:0] thr;
    logic [KNOTS-1:0]  at_or_below;
    logic              ok;
  } cmp_t;

  // after bracket selection
  typedef struct packed {
    logic [LEVEL_W-1:0] n;
    logic [TONE_W-1:0]  rem;
    logic [TONE_W-1:0]  span;
    logic [TONE_W-1:0]  thr;
    logic               white;
    logic               ok;
  } brk_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               invalid;
  } res_t;

endpackage

FILE: rtl/tcdq_knot_cmp.sv
// Stage 1: compares the sample against every knot and checks the curve.
module tcdq_knot_cmp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [7:0]               sample,
  input  logic [7:0]               thr,
  input  tcdq_pkg::knot_array_t    knots,
  input  logic                     down_ready,
  output logic                     ready,
  output logic                     valid,
  output tcdq_pkg::cmp_t           data
);

  tcdq_pkg::cmp_t data_next;

  always_comb begin
    data_next.sample = sample;
    data_next.thr = thr;
    data_next.ok = (knots[0] == tcdq_pkg::BLACK_TONE) &&
                   (knots[tcdq_pkg::KNOTS-1] == tcdq_pkg::WHITE_TONE);
    for (int i = 0; i < tcdq_pkg::KNOTS; i++) begin
      data_next.at_or_below[i] = (knots[i] <= sample);
    end
    for (int i = 1; i < tcdq_pkg::KNOTS; i++) begin
      if (knots[i] <= knots[i-1]) data_next.ok = 1'b0;
    end
  end

  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) data <= data_next;
  end

endmodule

FILE: rtl/tcdq_bracket.sv
// Stage 2: picks the bracket knot and forms remainder and span.
module tcdq_bracket (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  tcdq_pkg::cmp_t           in_data,
  input  tcdq_pkg::knot_array_t    knots,
  input  logic                     down_ready,
  output logic                     ready,
  output logic                     valid,
  output tcdq_pkg::brk_t           data
);

  tcdq_pkg::brk_t data_next;
  logic [tcdq_pkg::LEVEL_W-1:0] n;
  logic [tcdq_pkg::LEVEL_W-1:0] n_up;
  logic [tcdq_pkg::TONE_W-1:0]  lo_tone;
  logic [tcdq_pkg::TONE_W-1:0]  hi_tone;

  // highest knot at or below the sample; knot 0 stands when none is
  always_comb begin
    n = '0;
    for (int i = 1; i < tcdq_pkg::KNOTS; i++) begin
      if (in_data.at_or_below[i]) n = tcdq_pkg::LEVEL_W'(i);
    end
  end

  always_comb begin
    n_up = (n == tcdq_pkg::WHITE_LEVEL) ? n : n + 1'b1;
    lo_tone = knots[n];
    hi_tone = knots[n_up];
    data_next.n = n;
    data_next.rem = in_data.sample - lo_tone;
    data_next.span = hi_tone - lo_tone;
    data_next.thr = in_data.thr;
    data_next.white = (n == tcdq_pkg::WHITE_LEVEL);
    data_next.ok = in_data.ok;
  end

  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) data <= data_next;
  end

endmodule

FILE: rtl/tcdq_decide.sv
// Stage 3: dither decision and output register.
module tcdq_decide (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  tcdq_pkg::brk_t           in_data,
  input  logic                     down_ready,
  output logic                     ready,
  output logic                     valid,
  output tcdq_pkg::res_t           data
);

  tcdq_pkg::res_t data_next;
  logic [2*tcdq_pkg::TONE_W-1:0] weighted_thr;
  logic [2*tcdq_pkg::TONE_W-1:0] scaled_rem;

  always_comb begin
    weighted_thr = 16'(in_data.thr) * 16'(in_data.span);
    scaled_rem = {in_data.rem, 8'h00};
    data_next.invalid = !in_data.ok;
    if (!in_data.ok) begin
      data_next.level = tcdq_pkg::BLACK_LEVEL;
    end else if (in_data.white) begin
      data_next.level = tcdq_pkg::WHITE_LEVEL;
    end else if (weighted_thr < scaled_rem) begin
      data_next.level = in_data.n + 1'b1;
    end else begin
      data_next.level = in_data.n;
    end
  end

  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) data <= data_next;
  end

endmodule

FILE: rtl/tone_curve_dither_quantizer_unit.sv
// Top level of the tone curve dither quantizer.
// Takes one pixel per clock while pix_stall is low and returns one panel level per
// pixel through three register stages: knot compares and curve check, bracket
// selection, then the dither multiply and compare into the output register.
// Each stage holds its item while the next one is full and stalled, and empty stages
// keep taking pixels. The curve check is re-evaluated from the knot registers for
// every pixel; knot registers are written on any clock with cfg_write high.
module tone_curve_dither_quantizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [7:0]  gray_sample,
  input  logic [7:0]  dither_threshold,
  output logic        lvl_valid,
  input  logic        lvl_stall,
  output logic [3:0]  tone_level,
  output logic        curve_invalid,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [tcdq_pkg::CFG_W-1:0] knots_low_half;
  logic [tcdq_pkg::CFG_W-1:0] knots_high_half;
  tcdq_pkg::knot_array_t knots;

  logic cmp_ready, cmp_valid;
  logic brk_ready, brk_valid;
  logic dec_ready;
  tcdq_pkg::cmp_t cmp_data;
  tcdq_pkg::brk_t brk_data;
  tcdq_pkg::res_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_low_half <= tcdq_pkg::KNOTS_LOW_RESET;
      knots_high_half <= tcdq_pkg::KNOTS_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcdq_pkg::CFG_KNOTS_LOW:  knots_low_half <= cfg_data;
        tcdq_pkg::CFG_KNOTS_HIGH: knots_high_half <= cfg_data;
        default: ;
      endcase
    end
  end

  // knot i sits in byte i of the concatenated halves
  assign knots = {knots_high_half, knots_low_half};

  tcdq_knot_cmp u_cmp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix_valid),
    .sample     (gray_sample),
    .thr        (dither_threshold),
    .knots      (knots),
    .down_ready (brk_ready),
    .ready      (cmp_ready),
    .valid      (cmp_valid),
    .data       (cmp_data)
  );

  tcdq_bracket u_brk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmp_valid),
    .in_data    (cmp_data),
    .knots      (knots),
    .down_ready (dec_ready),
    .ready      (brk_ready),
    .valid      (brk_valid),
    .data       (brk_data)
  );

  tcdq_decide u_dec (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (brk_valid),
    .in_data    (brk_data),
    .down_ready (!lvl_stall),
    .ready      (dec_ready),
    .valid      (lvl_valid),
    .data       (res_data)
  );

  assign pix_stall = !cmp_ready;
  assign tone_level = res_data.level;
  assign curve_invalid = res_data.invalid;

`ifndef SYNTHESIS
  // a failed curve always reports black
  a_invalid_black: assert property (@(posedge clk) disable iff (rst)
    lvl_valid && curve_invalid |-> tone_level == tcdq_pkg::BLACK_LEVEL)
    else $error("invalid curve with nonzero level");

  // inside a valid bracket the sample stays below the upper knot
  a_rem_in_span: assert property (@(posedge clk) disable iff (rst)
    brk_valid && brk_data.ok && !brk_data.white |-> brk_data.rem < brk_data.span)
    else $error("remainder not below span");

  // stalling the source only happens with every stage full and the output stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> cmp_valid && brk_valid && lvl_valid && lvl_stall)
    else $error("source stalled with room in the pipeline");
`endif

endmodule
